[src/sfg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_pkg
// Shared types and constants of the spring force generator.
// ----------------------------------------------------------------------------
package sfg_pkg;

  localparam int unsigned MAG_W    = 32;  // |pos - anchor| fits in 32 bits
  localparam int unsigned SUM_W    = 66;  // sum of three squares
  localparam int unsigned ROOT_W   = SUM_W / 2;
  localparam int unsigned QUO_W    = 17;  // unit vector magnitude, at most 1.0
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SPRING_CONSTANT = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_REST_LENGTH     = cfg_idx_t'(1);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } out_word_t;

endpackage

[src/sfg_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sfg_isqrt
  import sfg_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  localparam int unsigned STAGES = ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;

  logic [SUM_W-1:0]  rad_r  [1:STAGES];
  logic [REM_W-1:0]  rem_r  [1:STAGES];
  logic [ROOT_W-1:0] root_r [1:STAGES];
  logic [SUM_W-1:0]  rad_nxt  [1:STAGES];
  logic [REM_W-1:0]  rem_nxt  [1:STAGES];
  logic [ROOT_W-1:0] root_nxt [1:STAGES];

  always_comb begin
    logic [SUM_W-1:0]  rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [1:0]        pair;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;
    for (int j = 1; j <= STAGES; j++) begin
      if (j == 1) begin
        rad_p  = rad;
        rem_p  = '0;
        root_p = '0;
      end else begin
        rad_p  = rad_r[j-1];
        rem_p  = rem_r[j-1];
        root_p = root_r[j-1];
      end
      pair  = 2'(rad_p >> (2 * (STAGES - j)));
      cand  = {rem_p, pair};
      trial = (REM_W+2)'({root_p, 2'b01});
      rad_nxt[j] = rad_p;
      if (cand >= trial) begin
        rem_nxt[j]  = REM_W'(cand - trial);
        root_nxt[j] = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = REM_W'(cand);
        root_nxt[j] = {root_p[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j <= STAGES; j++) begin
        rad_r[j]  <= rad_nxt[j];
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
    end
  end

  assign root = root_r[STAGES];

endmodule

[src/sfg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfg_div
// Pipelined restoring divider: (mag << 16) / len, one quotient bit a stage.
// ----------------------------------------------------------------------------
module sfg_div
  import sfg_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [MAG_W-1:0]  mag,
  input  logic [ROOT_W-1:0] len,
  output logic [QUO_W-1:0]  quo
);

  localparam int unsigned STAGES = QUO_W;

  logic [ROOT_W-1:0] rem_r [1:STAGES];
  logic [ROOT_W-1:0] len_r [1:STAGES];
  logic [QUO_W-1:0]  quo_r [1:STAGES];
  logic [ROOT_W-1:0] rem_nxt [1:STAGES];
  logic [ROOT_W-1:0] len_nxt [1:STAGES];
  logic [QUO_W-1:0]  quo_nxt [1:STAGES];

  // quotient never exceeds 2^16, so the top of the dividend starts as remainder
  always_comb begin
    logic [ROOT_W-1:0] rem_p;
    logic [ROOT_W-1:0] len_p;
    logic [QUO_W-1:0]  quo_p;
    logic              dbit;
    logic [ROOT_W:0]   cand;
    for (int j = 1; j <= STAGES; j++) begin
      if (j == 1) begin
        rem_p = ROOT_W'(mag[MAG_W-1:1]);
        len_p = len;
        quo_p = '0;
        dbit  = mag[0];
      end else begin
        rem_p = rem_r[j-1];
        len_p = len_r[j-1];
        quo_p = quo_r[j-1];
        dbit  = 1'b0;
      end
      cand       = {rem_p, dbit};
      len_nxt[j] = len_p;
      if (cand >= {1'b0, len_p}) begin
        rem_nxt[j] = ROOT_W'(cand - {1'b0, len_p});
        quo_nxt[j] = {quo_p[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[j] = ROOT_W'(cand);
        quo_nxt[j] = {quo_p[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j <= STAGES; j++) begin
        rem_r[j] <= rem_nxt[j];
        len_r[j] <= len_nxt[j];
        quo_r[j] <= quo_nxt[j];
      end
    end
  end

  assign quo = quo_r[STAGES];

endmodule

[src/spring_force_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_force_generator_core
// Hooke's law spring force between a particle and its anchor, Q16.16.
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out per cycle while the output is
// not stalled, through 55 register stages: three in front, the 33-stage square
// root, the 17-stage divider that follows it, one multiply stage and the output
// register. A stall on the output holds the whole pipeline; no word is dropped.
module spring_force_generator_core
  import sfg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned S_LEN  = 3 + ROOT_W;     // root available
  localparam int unsigned S_BIGM = S_LEN + 3;
  localparam int unsigned S_QUO  = S_LEN + QUO_W;
  localparam int unsigned S_PROD = S_QUO + 1;
  localparam int unsigned LAT    = S_PROD + 1;

  logic [31:0] k_r;
  logic [30:0] rest_r;

  logic adv;
  logic [LAT:1] vld_r;

  logic [MAG_W-1:0]  a_r   [1:S_LEN][3];
  logic [2:0]        sgn_r [1:S_PROD];
  logic [63:0]       sq_r  [3];
  logic [SUM_W-1:0]  sum_r;
  logic [ROOT_W-1:0] len;
  logic              lz_r  [S_LEN+1:S_PROD];
  logic [ROOT_W-1:0] m_r;
  logic [63:0]       p_r;
  logic              mhi_r;
  logic [48:0]       bigm_r [S_BIGM:S_QUO];
  logic [QUO_W-1:0]  quo    [3];
  logic [48:0]       plo_r  [3];
  logic [33:0]       phi_r  [3];
  out_word_t         out_r;

  logic [31:0] kmag;
  logic [31:0] pos   [3];
  logic [31:0] anc   [3];
  logic [31:0] frc   [3];

  assign adv       = !vld_r[LAT] || out_ready;
  assign in_ready  = adv && rst_n;
  assign cfg_ready = rst_n;
  assign kmag      = k_r[31] ? 32'(-k_r) : k_r;

  assign pos[0] = in_data.pos_x;
  assign pos[1] = in_data.pos_y;
  assign pos[2] = in_data.pos_z;
  assign anc[0] = in_data.anchor_x;
  assign anc[1] = in_data.anchor_y;
  assign anc[2] = in_data.anchor_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= 32'd65536;
      rest_r <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPRING_CONSTANT: k_r    <= cfg_data;
        CFG_REST_LENGTH:     rest_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  sfg_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (sum_r),
    .root (len)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    sfg_div u_div (
      .clk (clk),
      .en  (adv),
      .mag (a_r[S_LEN][g]),
      .len (len),
      .quo (quo[g])
    );
  end

  // final combine and saturate
  always_comb begin
    logic [50:0] f;
    for (int i = 0; i < 3; i++) begin
      f = 51'(plo_r[i] >> 16) + 51'({phi_r[i], 16'b0});
      if (lz_r[S_PROD]) begin
        frc[i] = '0;
      end else if (k_r[31] == sgn_r[S_PROD][i]) begin
        frc[i] = (f > 51'h8000_0000) ? 32'h8000_0000 : 32'(-f[31:0]);
      end else begin
        frc[i] = (f > 51'h7FFF_FFFF) ? 32'h7FFF_FFFF : f[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] d;
    if (adv) begin
      // difference and magnitude
      for (int i = 0; i < 3; i++) begin
        d = {pos[i][31], pos[i]} - {anc[i][31], anc[i]};
        sgn_r[1][i] <= d[32];
        a_r[1][i]   <= d[32] ? 32'(-d) : d[31:0];
      end
      for (int s = 2; s <= S_LEN; s++) a_r[s] <= a_r[s-1];
      for (int s = 2; s <= S_PROD; s++) sgn_r[s] <= sgn_r[s-1];
      for (int i = 0; i < 3; i++) sq_r[i] <= a_r[1][i] * a_r[1][i];
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      // spring stretch and scaled magnitude
      lz_r[S_LEN+1] <= (len == '0);
      for (int s = S_LEN + 2; s <= S_PROD; s++) lz_r[s] <= lz_r[s-1];
      m_r   <= (len >= ROOT_W'(rest_r)) ? len - ROOT_W'(rest_r) : ROOT_W'(rest_r) - len;
      p_r   <= kmag * m_r[31:0];
      mhi_r <= m_r[32];
      bigm_r[S_BIGM] <= 49'(p_r >> 16) + (mhi_r ? 49'({kmag, 16'b0}) : 49'd0);
      for (int s = S_BIGM + 1; s <= S_QUO; s++) bigm_r[s] <= bigm_r[s-1];
      for (int i = 0; i < 3; i++) begin
        plo_r[i] <= bigm_r[S_QUO][31:0] * quo[i];
        phi_r[i] <= bigm_r[S_QUO][48:32] * quo[i];
      end
      out_r.force_x <= frc[0];
      out_r.force_y <= frc[1];
      out_r.force_z <= frc[2];
    end
  end

  assign out_valid = vld_r[LAT];
  assign out_data  = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[S_PROD] && lz_r[S_PROD]) |=> (out_data == '0))
    else $error("zero length gave nonzero force");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !vld_r[LAT-1]) |=> !out_valid)
    else $error("output word without input");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for spring_force_generator_core.
// ----------------------------------------------------------------------------
// Each accepted input word is run through a local Hooke's law predictor, and
// the predicted force is queued. The returned forces are then checked in
// order, field by field. The stimulus is built as follows:
//   - a directed set covers extremes, zero length, the rest-length crossing
//     and sign cases;
//   - register writes sweep the stiffness and the rest length, including
//     their extremes and ignored indexes;
//   - random words are sent with random idles on both sides;
//   - one long receiver hold-off backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  import sfg_pkg::*;

  localparam int PIPE_DEPTH = 55;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic signed [31:0] stiffness;
  logic [30:0]        rest_len;
  out_word_t          force_q[$];
  int                 errors = 0;
  int                 tx_max = 4;
  int                 rx_max = 4;
  int                 rx_wait = 0;
  int                 rx_hold = 0;

  spring_force_generator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic out_word_t spring_force(in_word_t w);
    logic signed [31:0] p[3];
    logic signed [31:0] q[3];
    logic signed [32:0] d[3];
    logic [31:0]        dmag[3];
    logic [31:0]        f_out[3];
    logic [67:0]        sumsq;
    logic [69:0]        rem;
    logic [69:0]        root;
    logic [69:0]        trial;
    logic [34:0]        m;
    logic [31:0]        kmag;
    logic [79:0]        big_m;
    logic [47:0]        n;
    logic [127:0]       f;
    logic               neg;
    out_word_t          r;
    p = '{w.pos_x, w.pos_y, w.pos_z};
    q = '{w.anchor_x, w.anchor_y, w.anchor_z};
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({p[i][31], p[i]}) - $signed({q[i][31], q[i]});
      dmag[i] = d[i][32] ? 32'(-d[i]) : d[i][31:0];
      sumsq += 68'(dmag[i]) * 68'(dmag[i]);
    end
    rem = '0;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 70'(sumsq[2*i +: 2]);
      trial = (root << 2) | 70'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 70'd1;
      end else begin
        root = root << 1;
      end
    end
    m = (root[34:0] >= 35'(rest_len)) ? root[34:0] - 35'(rest_len)
                                       : 35'(rest_len) - root[34:0];
    kmag = stiffness[31] ? (~stiffness + 32'd1) : stiffness;
    big_m = (80'(kmag) * 80'(m)) >> 16;
    for (int i = 0; i < 3; i++) begin
      if (root == '0) begin
        f_out[i] = '0;
      end else begin
        n = {dmag[i], 16'b0} / 48'(root);
        f = (128'(big_m) * 128'(n)) >> 16;
        neg = (stiffness[31] == d[i][32]);
        if (neg) begin
          if (f > 128'h8000_0000) f = 128'h8000_0000;
          f_out[i] = ~f[31:0] + 32'd1;
        end else begin
          if (f > 128'h7FFF_FFFF) f = 128'h7FFF_FFFF;
          f_out[i] = f[31:0];
        end
      end
    end
    r.force_x = f_out[0];
    r.force_y = f_out[1];
    r.force_z = f_out[2];
    return r;
  endfunction

  // Coordinates: full range, clustered near zero, at the rails, or in a wider band around zero.
  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int       mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 7) ? 2 : 3;
    w.pos_x = rand_coord(mode);
    w.pos_y = rand_coord(mode);
    w.pos_z = rand_coord(mode);
    w.anchor_x = rand_coord(mode);
    w.anchor_y = rand_coord(mode);
    w.anchor_z = rand_coord(mode);
    // Sometimes collapse one or more axes, or the whole spring.
    if ($urandom_range(0, 7) == 0) w.anchor_x = w.pos_x;
    if ($urandom_range(0, 7) == 0) w.anchor_y = w.pos_y;
    if ($urandom_range(0, 7) == 0) w.anchor_z = w.pos_z;
    if ($urandom_range(0, 40) == 0) w[95:0] = w[191:96];
    return w;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = $urandom_range(0, tx_max);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    force_q = {force_q, spring_force(w)};
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SPRING_CONSTANT) stiffness = val;
    else if (idx == CFG_REST_LENGTH) rest_len = val[30:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_axes(input logic [31:0] px, py, pz, ax, ay, az);
    in_word_t w;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz;
    w.anchor_x = ax; w.anchor_y = ay; w.anchor_z = az;
    send_word(w);
  endtask

  task automatic test_directed();
    send_axes(0, 0, 0, 0, 0, 0);
    send_axes(32'h0001_0000, 0, 0, 0, 0, 0);
    send_axes(32'h0002_0000, 0, 0, 0, 0, 0);
    send_axes(0, 32'h0003_0000, 0, 0, 0, 0);
    send_axes(0, 0, 32'hFFFF_8000, 0, 0, 0);
    send_axes(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
    send_axes(1, 1, 1, 0, 0, 0);
    send_axes(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_axes(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_axes(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_axes(32'h1234_5678, 32'hDEAD_BEEF, 32'h0BAD_F00D,
              32'h1234_5678, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    send_axes(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_axes(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    logic [31:0] k_set[6];
    logic [31:0] r_set[5];
    k_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000, 32'h0000_0001,
              32'hFFFF_FFFF};
    r_set = '{32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0003_0000, 32'h8000_0005};
    foreach (k_set[i]) begin
      write_reg(CFG_SPRING_CONSTANT, k_set[i]);
      write_reg(CFG_REST_LENGTH, r_set[i % 5]);
      send_axes(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_axes(32'h0003_0000, 0, 0, 0, 0, 0);
      send_axes(0, 32'hFFFD_0000, 32'h0000_0005, 0, 0, 0);
      send_axes(0, 0, 0, 0, 0, 0);
      wait_drained();
    end
    // Writes to unmapped indexes must leave both registers untouched.
    write_reg(cfg_idx_t'(2), 32'h1234_5678);
    write_reg(cfg_idx_t'(255), 32'hFFFF_FFFF);
    send_axes(32'h0002_0000, 32'h0001_0000, 0, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: write_reg(CFG_SPRING_CONSTANT, 32'h0001_0000);
        1: write_reg(CFG_SPRING_CONSTANT, $urandom);
        2: write_reg(CFG_SPRING_CONSTANT, 32'($signed($urandom_range(0, 32'h0020_0000))
                                              - 32'sh0010_0000));
        default: write_reg(CFG_SPRING_CONSTANT, $urandom_range(0, 1) ? 32'h8000_0000
                                                                     : 32'h7FFF_FFFF);
      endcase
      write_reg(CFG_REST_LENGTH, (phase % 3 == 0) ? $urandom
                                                  : $urandom_range(0, 32'h0010_0000));
      // Alternate between bursty and back-to-back traffic.
      tx_max = (phase % 2) ? 0 : 4;
      rx_max = (phase % 3 == 1) ? 0 : 4;
      repeat (100) send_word(rand_word());
      wait_drained();
    end
    tx_max = 4;
    rx_max = 4;
  endtask

  task automatic test_backpressure();
    tx_max = 0;
    rx_hold = 300;
    repeat (150) send_word(rand_word());
    wait_drained();
    tx_max = 4;
  endtask

  // Receiver: random stalls per word plus an optional long hold.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (force_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        exp_w = force_q.pop_front();
        report("force_x", exp_w.force_x, out_data.force_x);
        report("force_y", exp_w.force_y, out_data.force_y);
        report("force_z", exp_w.force_z, out_data.force_z);
      end
      rx_wait = $urandom_range(0, rx_max);
    end
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    stiffness = 32'sh0001_0000;
    rest_len = 31'h0001_0000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_random_traffic();
    test_backpressure();
    repeat (300) send_word(rand_word());
    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
